// ===== rtl/gmab_pkg.sv =====
// Package for the grain-merge alpha blend: fixed-point constants, register indexes,
// the pipeline control struct and the byte to Q16 conversion.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package gmab_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned Q_W      = 17;
   localparam int unsigned WEIGHT_W = 9;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned STAGES   = 5;

   localparam logic [Q_W-1:0]      Q_ONE      = 17'd65536;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd77;

   localparam logic [CSR_IDX_W-1:0] CSR_TEXTURE_ALPHA_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIN_WEIGHT        = 2'd1;

   // Load strobes for the five compute stages, shared by the alpha unit and the lanes.
   typedef struct packed {
      logic [STAGES-1:0] load;
   } gmab_ctl_type;

   // ceil(b * 65536 / 255) equals b * 257 plus one for any nonzero byte.
   function automatic logic [Q_W-1:0] to_q16(input logic [BYTE_W-1:0] b);
      return {1'b0, b, b} + Q_W'(b != '0);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gmab_alpha.sv =====
// Effective alpha unit: converts the alpha bytes and, in RGBA mode, multiplies them.
// Delivers the alpha to the lanes at stage 3 and again, delayed, at stage 5.
// Depends on gmab_pkg.
`default_nettype none

module gmab_alpha
   import gmab_pkg::*;
(
   input  wire logic                 clock,
   input  wire gmab_ctl_type         ctl,
   input  wire logic                 texture_alpha_mode,
   input  wire logic [BYTE_W-1:0]    image_alpha,
   input  wire logic [BYTE_W-1:0]    tex_alpha,
   output logic      [Q_W-1:0]       alpha_early,
   output logic      [Q_W-1:0]       alpha_late
);

   logic [Q_W-1:0]   img_q_ff;
   logic [Q_W-1:0]   tex_q_ff;
   logic [Q_W-1:0]   alpha2_ff;
   logic [Q_W-1:0]   alpha2_in;
   logic [Q_W-1:0]   alpha3_ff;
   logic [Q_W-1:0]   alpha4_ff;
   logic [2*Q_W:0]   product;

   always_comb begin
      product = (2*Q_W+1)'(img_q_ff) * (2*Q_W+1)'(tex_q_ff) + (2*Q_W+1)'(Q_ONE >> 1);
      if (texture_alpha_mode) begin
         alpha2_in = product[Q_W+15:16];
      end else begin
         alpha2_in = img_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         img_q_ff <= to_q16(image_alpha);
         tex_q_ff <= to_q16(tex_alpha);
      end
      if (ctl.load[1]) begin
         alpha2_ff <= alpha2_in;
      end
      if (ctl.load[2]) begin
         alpha3_ff <= alpha2_ff;
      end
      if (ctl.load[3]) begin
         alpha4_ff <= alpha3_ff;
      end
   end

   assign alpha_early = alpha2_ff;
   assign alpha_late  = alpha4_ff;

endmodule

`default_nettype wire

// ===== rtl/gmab_lane.sv =====
// One color channel lane: grain merge, texture blend, skin mix and base blend
// over five registered stages. Depends on gmab_pkg.
`default_nettype none

module gmab_lane
   import gmab_pkg::*;
(
   input  wire logic                  clock,
   input  wire gmab_ctl_type          ctl,
   input  wire logic [WEIGHT_W-1:0]   weight,
   input  wire logic [Q_W-1:0]        alpha_early,
   input  wire logic [Q_W-1:0]        alpha_late,
   input  wire logic [BYTE_W-1:0]     base_byte,
   input  wire logic [BYTE_W-1:0]     tex_byte,
   input  wire logic [BYTE_W-1:0]     skin_byte,
   output logic      [Q_W-1:0]        result
);

   logic [Q_W-1:0] base1_ff, tex1_ff, skin1_ff, gm1_ff;
   logic [Q_W-1:0] base2_ff, tex2_ff, skin2_ff, gm2_ff;
   logic [Q_W-1:0] base3_ff, skin3_ff, g3_ff;
   logic [Q_W-1:0] base4_ff, g4_ff;
   logic [Q_W-1:0] r5_ff;

   logic [Q_W-1:0] tex_q, skin_q, gm1_in, g3_in, g4_in, r5_in;
   logic [Q_W:0]   sum1;

   logic signed [Q_W:0]       diff3, diff4, diff5;
   logic signed [2*Q_W+1:0]   prod3, sum3, prod5, sum5;
   logic signed [Q_W+10:0]    prod4, sum4;

   always_comb begin
      tex_q  = to_q16(tex_byte);
      skin_q = to_q16(skin_byte);
      sum1   = {1'b0, tex_q} + {1'b0, skin_q};
      if (sum1 < (Q_W+1)'(Q_ONE >> 1)) begin
         gm1_in = '0;
      end else if (sum1 > (Q_W+1)'(Q_ONE) + (Q_W+1)'(Q_ONE >> 1)) begin
         gm1_in = Q_ONE;
      end else begin
         gm1_in = Q_W'(sum1 - (Q_W+1)'(Q_ONE >> 1));
      end
   end

   // The blends are written as Y*1 + (X - Y)*A so each blend stage has a single multiplier.
   always_comb begin
      diff3 = $signed({1'b0, gm2_ff}) - $signed({1'b0, tex2_ff});
      prod3 = diff3 * $signed({1'b0, alpha_early});
      sum3  = $signed({3'b0, tex2_ff, 16'b0}) + prod3 + (2*Q_W+2)'(Q_ONE >> 1);
      g3_in = sum3[Q_W+15:16];
   end

   always_comb begin
      diff4 = $signed({1'b0, skin3_ff}) - $signed({1'b0, g3_ff});
      prod4 = diff4 * $signed({1'b0, weight});
      sum4  = $signed({3'b0, g3_ff, 8'b0}) + prod4 + (Q_W+11)'(WEIGHT_ONE >> 1);
      g4_in = sum4[Q_W+7:8];
   end

   always_comb begin
      diff5 = $signed({1'b0, g4_ff}) - $signed({1'b0, base4_ff});
      prod5 = diff5 * $signed({1'b0, alpha_late});
      sum5  = $signed({3'b0, base4_ff, 16'b0}) + prod5 + (2*Q_W+2)'(Q_ONE >> 1);
      r5_in = sum5[Q_W+15:16];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         base1_ff <= to_q16(base_byte);
         tex1_ff  <= tex_q;
         skin1_ff <= skin_q;
         gm1_ff   <= gm1_in;
      end
      if (ctl.load[1]) begin
         base2_ff <= base1_ff;
         tex2_ff  <= tex1_ff;
         skin2_ff <= skin1_ff;
         gm2_ff   <= gm1_ff;
      end
      if (ctl.load[2]) begin
         base3_ff <= base2_ff;
         skin3_ff <= skin2_ff;
         g3_ff    <= g3_in;
      end
      if (ctl.load[3]) begin
         base4_ff <= base3_ff;
         g4_ff    <= g4_in;
      end
      if (ctl.load[4]) begin
         r5_ff <= r5_in;
      end
   end

   assign result = r5_ff;

endmodule

`default_nettype wire

// ===== rtl/gmab_merge.sv =====
// Output stage: scales the three lane results to bytes and holds the result beat
// until the consumer takes it. Depends on gmab_pkg.
`default_nettype none

module gmab_merge
   import gmab_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [Q_W-1:0]      red_q,
   input  wire logic [Q_W-1:0]      green_q,
   input  wire logic [Q_W-1:0]      blue_q,
   input  wire logic                in_last,
   output logic                     in_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [BYTE_W-1:0]   rsp_out_red,
   output logic      [BYTE_W-1:0]   rsp_out_green,
   output logic      [BYTE_W-1:0]   rsp_out_blue,
   output logic                     rsp_last_out
);

   logic                valid_ff;
   logic [BYTE_W-1:0]   red_ff, green_ff, blue_ff;
   logic                last_ff;

   // (r * 255) >> 16, clamped to a byte.
   function automatic logic [BYTE_W-1:0] to_byte(input logic [Q_W-1:0] r);
      logic [Q_W+7:0] scaled;
      scaled = {r, 8'b0} - (Q_W+8)'(r);
      if (scaled[Q_W+7:16] > (Q_W-8)'(8'hFF)) begin
         return 8'hFF;
      end else begin
         return scaled[23:16];
      end
   endfunction

   assign in_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         red_ff   <= to_byte(red_q);
         green_ff <= to_byte(green_q);
         blue_ff  <= to_byte(blue_q);
         last_ff  <= in_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_red   = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue  = blue_ff;
   assign rsp_last_out  = last_ff;

   // A beat taken with nothing behind it leaves the output empty.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_stall && !in_valid |=> !valid_ff)
      else $error("output beat repeated after it was taken");

   // A waiting beat blocks the stage in front of it.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |-> !in_ready)
      else $error("output stage accepts while its beat waits");

   // A new beat appears only when the stage in front offered one.
   assert property (@(posedge clock) disable iff (reset)
      in_ready && !in_valid |=> !valid_ff)
      else $error("output beat without a source");

endmodule

`default_nettype wire

// ===== rtl/grain_merge_alpha_blend.sv =====
// Grain-merge alpha blend, one pixel per beat. The block takes a new pixel every clock
// cycle while req_stall is low; each result passes through five compute stages,
// each with at most one multiplier, then an output register. The three color channels
// run in parallel lanes beside a shared alpha unit; a stall on the result side holds the
// pipeline back one stage at a time, so req_stall rises only when every stage is full.
// Configuration registers should be written only while the pipeline is empty.
`default_nettype none

module grain_merge_alpha_blend
   import gmab_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_wr_index,
   input  wire logic [WEIGHT_W-1:0]    csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [BYTE_W-1:0]      req_base_red,
   input  wire logic [BYTE_W-1:0]      req_base_green,
   input  wire logic [BYTE_W-1:0]      req_base_blue,
   input  wire logic [BYTE_W-1:0]      req_tex_red,
   input  wire logic [BYTE_W-1:0]      req_tex_green,
   input  wire logic [BYTE_W-1:0]      req_tex_blue,
   input  wire logic [BYTE_W-1:0]      req_tex_alpha,
   input  wire logic [BYTE_W-1:0]      req_skin_red,
   input  wire logic [BYTE_W-1:0]      req_skin_green,
   input  wire logic [BYTE_W-1:0]      req_skin_blue,
   input  wire logic [BYTE_W-1:0]      req_image_alpha,
   input  wire logic                   req_last_in,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [BYTE_W-1:0]      rsp_out_red,
   output logic      [BYTE_W-1:0]      rsp_out_green,
   output logic      [BYTE_W-1:0]      rsp_out_blue,
   output logic                        rsp_last_out
);

   logic                  mode_ff;
   logic [WEIGHT_W-1:0]   weight_ff;
   logic [STAGES-1:0]     valid_ff;
   logic [STAGES-1:0]     last_ff;
   logic [STAGES-1:0]     ready;
   logic                  merge_ready;
   gmab_ctl_type          ctl;
   logic [Q_W-1:0]        alpha_early, alpha_late;
   logic [Q_W-1:0]        red_q, green_q, blue_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         weight_ff <= WEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_wr_index)
            CSR_TEXTURE_ALPHA_MODE: begin
               mode_ff <= csr_wr_data[0];
            end
            CSR_SKIN_WEIGHT: begin
               weight_ff <= (csr_wr_data > WEIGHT_ONE) ? WEIGHT_ONE : csr_wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      ready[STAGES-1] = !valid_ff[STAGES-1] || merge_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign ctl.load  = ready;
   assign req_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         last_ff[0] <= req_last_in;
      end
      for (int i = 1; i < STAGES; i++) begin
         if (ready[i]) begin
            last_ff[i] <= last_ff[i-1];
         end
      end
   end

   gmab_alpha u_alpha (
      .clock              (clock),
      .ctl                (ctl),
      .texture_alpha_mode (mode_ff),
      .image_alpha        (req_image_alpha),
      .tex_alpha          (req_tex_alpha),
      .alpha_early        (alpha_early),
      .alpha_late         (alpha_late)
   );

   gmab_lane u_lane_red (
      .clock       (clock),
      .ctl         (ctl),
      .weight      (weight_ff),
      .alpha_early (alpha_early),
      .alpha_late  (alpha_late),
      .base_byte   (req_base_red),
      .tex_byte    (req_tex_red),
      .skin_byte   (req_skin_red),
      .result      (red_q)
   );

   gmab_lane u_lane_green (
      .clock       (clock),
      .ctl         (ctl),
      .weight      (weight_ff),
      .alpha_early (alpha_early),
      .alpha_late  (alpha_late),
      .base_byte   (req_base_green),
      .tex_byte    (req_tex_green),
      .skin_byte   (req_skin_green),
      .result      (green_q)
   );

   gmab_lane u_lane_blue (
      .clock       (clock),
      .ctl         (ctl),
      .weight      (weight_ff),
      .alpha_early (alpha_early),
      .alpha_late  (alpha_late),
      .base_byte   (req_base_blue),
      .tex_byte    (req_tex_blue),
      .skin_byte   (req_skin_blue),
      .result      (blue_q)
   );

   gmab_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (valid_ff[STAGES-1]),
      .red_q         (red_q),
      .green_q       (green_q),
      .blue_q        (blue_q),
      .in_last       (last_ff[STAGES-1]),
      .in_ready      (merge_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_last_out  (rsp_last_out)
   );

   // The stored weight is always saturated to one.
   assert property (@(posedge clock) disable iff (reset)
      weight_ff <= WEIGHT_ONE)
      else $error("skin weight above one");

   // With the consumer taking beats, the pipeline never pushes back.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

   // An empty first stage always takes a beat.
   assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> !req_stall)
      else $error("input stalled with an empty first stage");

   // A beat accepted into an open pipeline reaches the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted beat lost at the first stage");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for grain_merge_alpha_blend: pixels are driven through a queue-fed
// driver, every result beat is checked against a fixed-point model of the blend held here.
// Depends on gmab_pkg and the block itself.

module tb;
   import gmab_pkg::*;

   localparam int HOLD_CYCLES    = 48;
   localparam int SETTLE_CYCLES  = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 200;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_B = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] base_red;
      logic [BYTE_W-1:0] base_green;
      logic [BYTE_W-1:0] base_blue;
      logic [BYTE_W-1:0] tex_red;
      logic [BYTE_W-1:0] tex_green;
      logic [BYTE_W-1:0] tex_blue;
      logic [BYTE_W-1:0] tex_alpha;
      logic [BYTE_W-1:0] skin_red;
      logic [BYTE_W-1:0] skin_green;
      logic [BYTE_W-1:0] skin_blue;
      logic [BYTE_W-1:0] image_alpha;
      logic              last_in;
   } pixel_in_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_red;
      logic [BYTE_W-1:0] out_green;
      logic [BYTE_W-1:0] out_blue;
      logic              last_out;
   } blend_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_wr_index = '0;
   logic [WEIGHT_W-1:0]   csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_base_red = '0;
   logic [BYTE_W-1:0]     req_base_green = '0;
   logic [BYTE_W-1:0]     req_base_blue = '0;
   logic [BYTE_W-1:0]     req_tex_red = '0;
   logic [BYTE_W-1:0]     req_tex_green = '0;
   logic [BYTE_W-1:0]     req_tex_blue = '0;
   logic [BYTE_W-1:0]     req_tex_alpha = '0;
   logic [BYTE_W-1:0]     req_skin_red = '0;
   logic [BYTE_W-1:0]     req_skin_green = '0;
   logic [BYTE_W-1:0]     req_skin_blue = '0;
   logic [BYTE_W-1:0]     req_image_alpha = '0;
   logic                  req_last_in = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_out_red;
   logic [BYTE_W-1:0]     rsp_out_green;
   logic [BYTE_W-1:0]     rsp_out_blue;
   logic                  rsp_last_out;

   pixel_in_type   pixels_to_send[$];
   blend_out_type  blends_due[$];
   logic        cfg_rgba = 1'b0;
   logic [WEIGHT_W-1:0] cfg_weight = WEIGHT_RESET;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_wanted = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_count = 0;
   logic        pixel_taken = 1'b0;
   int          mismatches = 0;
   int          quiet_cycles = 0;

   grain_merge_alpha_blend dut (.*);

   always #5 clock = ~clock;

   function automatic logic [16:0] unorm_to_q16(input logic [BYTE_W-1:0] b);
      return 17'(((32'(b) << 16) + 32'd254) / 32'd255);
   endfunction

   function automatic logic [16:0] alpha_lerp(input logic [16:0] x, input logic [16:0] y,
                                              input logic [16:0] a);
      logic [35:0] sum;
      sum = 36'(x) * 36'(a) + 36'(y) * (36'd65536 - 36'(a)) + 36'd32768;
      return 17'(sum >> 16);
   endfunction

   function automatic logic [BYTE_W-1:0] blend_channel(input logic [BYTE_W-1:0] base_b,
         input logic [BYTE_W-1:0] tex_b, input logic [BYTE_W-1:0] skin_b,
         input logic [16:0] a, input logic [WEIGHT_W-1:0] w);
      logic [16:0] bq;
      logic [16:0] tq;
      logic [16:0] sq;
      logic [16:0] g;
      logic [16:0] r;
      int          merged;
      logic [35:0] mix;
      logic [35:0] scaled;
      bq = unorm_to_q16(base_b);
      tq = unorm_to_q16(tex_b);
      sq = unorm_to_q16(skin_b);
      merged = int'(tq) + int'(sq) - 32768;
      if (merged < 0) merged = 0;
      if (merged > 65536) merged = 65536;
      g = alpha_lerp(17'(merged), tq, a);
      mix = 36'(g) * (36'd256 - 36'(w)) + 36'(sq) * 36'(w) + 36'd128;
      g = 17'(mix >> 8);
      r = alpha_lerp(g, bq, a);
      scaled = (36'(r) * 36'd255) >> 16;
      return (scaled > 36'd255) ? 8'd255 : 8'(scaled);
   endfunction

   function automatic blend_out_type blend_pixel(input pixel_in_type p, input logic rgba,
                                                 input logic [WEIGHT_W-1:0] weight);
      blend_out_type       res;
      logic [16:0]         a;
      logic [WEIGHT_W-1:0] w;
      a = unorm_to_q16(p.image_alpha);
      w = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
      if (rgba)
         a = 17'((36'(unorm_to_q16(p.tex_alpha)) * 36'(a) + 36'd32768) >> 16);
      res.out_red   = blend_channel(p.base_red, p.tex_red, p.skin_red, a, w);
      res.out_green = blend_channel(p.base_green, p.tex_green, p.skin_green, a, w);
      res.out_blue  = blend_channel(p.base_blue, p.tex_blue, p.skin_blue, a, w);
      res.last_out  = p.last_in;
      return res;
   endfunction

   function automatic pixel_in_type make_pixel(input logic [7:0] b_r, input logic [7:0] b_g,
         input logic [7:0] b_b, input logic [7:0] t_r, input logic [7:0] t_g,
         input logic [7:0] t_b, input logic [7:0] t_a, input logic [7:0] s_r,
         input logic [7:0] s_g, input logic [7:0] s_b, input logic [7:0] i_a,
         input logic last);
      return '{b_r, b_g, b_b, t_r, t_g, t_b, t_a, s_r, s_g, s_b, i_a, last};
   endfunction

   function automatic logic [BYTE_W-1:0] random_unorm();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'd0;
      if (pick == 1) return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic pixel_in_type random_pixel();
      return make_pixel(random_unorm(), random_unorm(), random_unorm(), random_unorm(),
                        random_unorm(), random_unorm(), random_unorm(), random_unorm(),
                        random_unorm(), random_unorm(), random_unorm(),
                        $urandom_range(0, 15) == 0);
   endfunction

   // Driver: a beat stays on the port until it is taken.
   always @(negedge clock) begin
      pixel_in_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || pixel_taken) begin
         if (pixels_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            p = pixels_to_send.pop_front();
            req_base_red    <= p.base_red;
            req_base_green  <= p.base_green;
            req_base_blue   <= p.base_blue;
            req_tex_red     <= p.tex_red;
            req_tex_green   <= p.tex_green;
            req_tex_blue    <= p.tex_blue;
            req_tex_alpha   <= p.tex_alpha;
            req_skin_red    <= p.skin_red;
            req_skin_green  <= p.skin_green;
            req_skin_blue   <= p.skin_blue;
            req_image_alpha <= p.image_alpha;
            req_last_in     <= p.last_in;
            req_valid       <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_wanted && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Monitor: predicts on each accepted pixel and checks each accepted result.
   always @(posedge clock) begin
      pixel_in_type  p;
      blend_out_type want;
      if (reset) begin
         pixel_taken <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         pixel_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            p = make_pixel(req_base_red, req_base_green, req_base_blue, req_tex_red,
                           req_tex_green, req_tex_blue, req_tex_alpha, req_skin_red,
                           req_skin_green, req_skin_blue, req_image_alpha, req_last_in);
            blends_due.push_back(blend_pixel(p, cfg_rgba, cfg_weight));
         end
         if (rsp_valid && !rsp_stall) begin
            if (blends_due.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: expected no beat, got r=%0d g=%0d b=%0d last=%0d", $time,
                           rsp_out_red, rsp_out_green, rsp_out_blue, rsp_last_out);
            end else begin
               want = blends_due.pop_front();
               if (want.out_red !== rsp_out_red || want.out_green !== rsp_out_green ||
                   want.out_blue !== rsp_out_blue || want.last_out !== rsp_last_out) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < REPORT_LIMIT)
                     $display("%0t: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
                              $time, want.out_red, want.out_green, want.out_blue,
                              want.last_out, rsp_out_red, rsp_out_green, rsp_out_blue,
                              rsp_last_out);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL grain_merge_alpha_blend");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [WEIGHT_W-1:0] data);
      @(negedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_index <= idx;
      csr_wr_data  <= data;
      if (idx == CSR_TEXTURE_ALPHA_MODE) cfg_rgba = data[0];
      else if (idx == CSR_SKIN_WEIGHT) cfg_weight = data;
   endtask

   task automatic configure(input logic [WEIGHT_W-1:0] mode_data,
                            input logic [WEIGHT_W-1:0] weight_data);
      csr_write(CSR_TEXTURE_ALPHA_MODE, mode_data);
      csr_write(CSR_SKIN_WEIGHT, weight_data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // The queues are checked at the rising edge, where the driver's state has settled.
   task automatic drain();
      while (pixels_to_send.size() != 0 || req_valid || blends_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_random(input int count, input int send_idle, input int stall_idle);
      send_idle_pct = send_idle;
      stall_pct = stall_idle;
      repeat (count) pixels_to_send.push_back(random_pixel());
      drain();
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: RGB mode, default weight. Texture alpha must have no effect.
      pixels_to_send.push_back(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pixels_to_send.push_back(make_pixel(255, 255, 255, 255, 255, 255, 255, 255, 255,
                                          255, 255, 1));
      pixels_to_send.push_back(make_pixel(0, 0, 0, 255, 255, 255, 0, 255, 255, 255,
                                          255, 0));
      pixels_to_send.push_back(make_pixel(255, 255, 255, 0, 0, 0, 255, 0, 0, 0, 255, 0));
      pixels_to_send.push_back(make_pixel(200, 100, 50, 10, 20, 30, 255, 240, 230, 220,
                                          0, 1));
      pixels_to_send.push_back(make_pixel(128, 128, 128, 128, 128, 128, 255, 128, 128,
                                          128, 128, 0));
      pixels_to_send.push_back(make_pixel(255, 0, 128, 0, 255, 64, 17, 128, 64, 255,
                                          200, 0));
      pixels_to_send.push_back(make_pixel(8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA,
                                          8'hAA, 8'hAA, 8'hAA, 8'hAA, 0));
      pixels_to_send.push_back(make_pixel(8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55,
                                          8'h55, 8'h55, 8'h55, 8'h55, 1));
      pixels_to_send.push_back(make_pixel(3, 250, 90, 60, 190, 1, 254, 33, 77, 254, 1, 0));
      drain();

      // Writes to unmapped indexes are ignored; mode takes only bit zero.
      csr_write(CSR_UNMAPPED_A, 9'h1FF);
      csr_write(CSR_UNMAPPED_B, 9'h000);
      configure(9'h101, 9'd0);
      pixels_to_send.push_back(make_pixel(255, 255, 255, 0, 0, 0, 0, 255, 255, 255,
                                          255, 0));
      pixels_to_send.push_back(make_pixel(0, 0, 0, 255, 255, 255, 255, 255, 255, 255,
                                          255, 1));
      pixels_to_send.push_back(make_pixel(40, 80, 120, 128, 128, 128, 128, 128, 128, 128,
                                          128, 0));
      pixels_to_send.push_back(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                                          8'h55, 8'hAA, 8'h55, 8'hAA, 0));
      pixels_to_send.push_back(make_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                                          8'hAA, 8'h55, 8'hAA, 8'h55, 1));
      pixels_to_send.push_back(make_pixel(12, 200, 99, 250, 5, 130, 77, 180, 66, 3, 230, 0));
      drain();

      // A weight above the full scale saturates.
      configure(9'h001, 9'h1FF);
      pixels_to_send.push_back(make_pixel(10, 20, 30, 200, 100, 0, 180, 255, 0, 128,
                                          160, 0));
      pixels_to_send.push_back(make_pixel(255, 0, 255, 0, 255, 0, 255, 90, 180, 45,
                                          255, 1));
      pixels_to_send.push_back(make_pixel(0, 128, 255, 128, 0, 255, 64, 0, 255, 128,
                                          64, 0));
      drain();
      configure(9'h1FE, 9'd300);
      pixels_to_send.push_back(make_pixel(10, 20, 30, 200, 100, 0, 180, 255, 0, 128,
                                          160, 0));
      pixels_to_send.push_back(make_pixel(255, 0, 255, 0, 255, 0, 255, 90, 180, 45,
                                          255, 1));
      pixels_to_send.push_back(make_pixel(0, 128, 255, 128, 0, 255, 64, 0, 255, 128,
                                          64, 0));
      drain();

      configure(9'd1, 9'd256);
      run_random(100, 0, 0);
      configure(9'h1FE, 9'h1FF);
      run_random(130, 88, 0);
      configure(9'd1, 9'd77);
      run_random(130, 0, 88);
      configure(9'd0, 9'($urandom_range(0, 256)));
      run_random(130, 33, 33);
      configure(9'd1, 9'd300);
      hold_wanted = 1'b1;
      run_random(120, 0, 0);
      configure(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
      run_random(120, 33, 33);
      configure(9'd0, 9'd0);
      run_random(120, 0, 0);

      if (mismatches == 0 && blends_due.size() == 0) begin
         $display("PASS grain_merge_alpha_blend");
      end else begin
         $display("FAIL grain_merge_alpha_blend");
      end
      $finish;
   end

endmodule
